// ===== design/pcmmix_pkg.sv =====
`default_nettype none

package pcmmix_pkg;

  localparam int Voices          = 8;
  localparam int SamplesPerVoice = 4096;
  localparam int OutputRate      = 44100;

  localparam int VoiceW  = (Voices > 1) ? $clog2(Voices) : 1;
  localparam int PosW    = $clog2(SamplesPerVoice);
  localparam int LenW    = $clog2(SamplesPerVoice + 1);
  localparam int PhaseW  = $clog2(OutputRate + 15600);
  localparam int MemAW   = VoiceW + PosW;
  localparam int MemDepth = Voices * (2 ** PosW);

  localparam int CmdW    = 3;
  localparam int ChanW   = 4;
  localparam int AddrW   = 12;
  localparam int SampleW = 12;
  localparam int LengthW = 13;
  localparam int RateW   = 8;
  localparam int VolW    = 8;
  localparam int MixW    = 32;
  localparam int MaskW   = 8;
  localparam int GainW   = 16;
  localparam int ProdW   = SampleW + GainW + 1;
  localparam int LevelW  = 17;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD   = 3'd0,
    CMD_PLAY   = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_VOLUME = 3'd3,
    CMD_RATE   = 3'd4,
    CMD_TICK   = 3'd5
  } cmd_e;

  typedef struct packed {
    logic              load_item;
    logic              apply;
    logic              issue;
    logic [VoiceW-1:0] vidx;
    logic              load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_sts_t;

  function automatic logic [13:0] rate_of(input logic [2:0] sel);
    logic [13:0] r;
    case (sel)
      3'd0:    r = 14'd3900;
      3'd1:    r = 14'd5200;
      3'd3:    r = 14'd10400;
      3'd4:    r = 14'd15600;
      default: r = 14'd7800;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] rate_sel(input logic [RateW-1:0] r);
    return (r < 8'd5) ? r[2:0] : 3'd2;
  endfunction

  function automatic logic [7:0] low_map(input logic [3:0] c);
    logic [7:0] m;
    case (c)
      4'd0:    m = 8'h6B;
      4'd1:    m = 8'h6F;
      4'd2:    m = 8'h71;
      4'd3:    m = 8'h74;
      4'd4:    m = 8'h76;
      4'd5:    m = 8'h79;
      4'd6:    m = 8'h7B;
      4'd7:    m = 8'h7D;
      4'd8:    m = 8'h80;
      4'd9:    m = 8'h82;
      4'd10:   m = 8'h84;
      4'd11:   m = 8'h87;
      4'd12:   m = 8'h8A;
      4'd13:   m = 8'h8C;
      4'd14:   m = 8'h8F;
      default: m = 8'h91;
    endcase
    return m;
  endfunction

  function automatic logic [GainW-1:0] gain_tbl(input logic [6:0] i);
    logic [GainW-1:0] g;
    case (i)
      7'd0: g = 16'd5;       7'd1: g = 16'd6;       7'd2: g = 16'd6;
      7'd3: g = 16'd7;       7'd4: g = 16'd7;       7'd5: g = 16'd8;
      7'd6: g = 16'd9;       7'd7: g = 16'd10;      7'd8: g = 16'd10;
      7'd9: g = 16'd11;      7'd10: g = 16'd12;     7'd11: g = 16'd14;
      7'd12: g = 16'd15;     7'd13: g = 16'd16;     7'd14: g = 16'd18;
      7'd15: g = 16'd20;     7'd16: g = 16'd21;     7'd17: g = 16'd23;
      7'd18: g = 16'd25;     7'd19: g = 16'd29;     7'd20: g = 16'd31;
      7'd21: g = 16'd33;     7'd22: g = 16'd37;     7'd23: g = 16'd41;
      7'd24: g = 16'd46;     7'd25: g = 16'd50;     7'd26: g = 16'd54;
      7'd27: g = 16'd60;     7'd28: g = 16'd66;     7'd29: g = 16'd72;
      7'd30: g = 16'd80;     7'd31: g = 16'd89;     7'd32: g = 16'd97;
      7'd33: g = 16'd107;    7'd34: g = 16'd117;    7'd35: g = 16'd130;
      7'd36: g = 16'd142;    7'd37: g = 16'd156;    7'd38: g = 16'd173;
      7'd39: g = 16'd189;    7'd40: g = 16'd205;    7'd41: g = 16'd226;
      7'd42: g = 16'd246;    7'd43: g = 16'd267;    7'd44: g = 16'd308;
      7'd45: g = 16'd328;    7'd46: g = 16'd369;    7'd47: g = 16'd410;
      7'd48: g = 16'd431;    7'd49: g = 16'd492;    7'd50: g = 16'd533;
      7'd51: g = 16'd594;    7'd52: g = 16'd656;    7'd53: g = 16'd717;
      7'd54: g = 16'd799;    7'd55: g = 16'd861;    7'd56: g = 16'd963;
      7'd57: g = 16'd1045;   7'd58: g = 16'd1147;   7'd59: g = 16'd1270;
      7'd60: g = 16'd1393;   7'd61: g = 16'd1536;   7'd62: g = 16'd1700;
      7'd63: g = 16'd1864;   7'd64: g = 16'd2048;   7'd65: g = 16'd2253;
      7'd66: g = 16'd2479;   7'd67: g = 16'd2724;   7'd68: g = 16'd2991;
      7'd69: g = 16'd3298;   7'd70: g = 16'd3625;   7'd71: g = 16'd3994;
      7'd72: g = 16'd4383;   7'd73: g = 16'd4834;   7'd74: g = 16'd5325;
      7'd75: g = 16'd5837;   7'd76: g = 16'd6431;   7'd77: g = 16'd7087;
      7'd78: g = 16'd7783;   7'd79: g = 16'd8561;   7'd80: g = 16'd9442;
      7'd81: g = 16'd10363;  7'd82: g = 16'd11387;  7'd83: g = 16'd12555;
      7'd84: g = 16'd13824;  7'd85: g = 16'd15217;  7'd86: g = 16'd16733;
      7'd87: g = 16'd18371;  7'd88: g = 16'd20255;  7'd89: g = 16'd22221;
      7'd90: g = 16'd24454;  7'd91: g = 16'd26932;  7'd92: g = 16'd29696;
      7'd93: g = 16'd32768;  7'd94: g = 16'd36127;  7'd95: g = 16'd39732;
      7'd96: g = 16'd43541;
      default: g = 16'd0;
    endcase
    return g;
  endfunction

  function automatic logic [GainW-1:0] gain_of(input logic [VolW-1:0] code);
    logic [7:0] m;
    logic [GainW-1:0] g;
    m = low_map(code[3:0]) - 8'h40;
    if (code <= 8'd15) begin
      g = gain_tbl(m[6:0]);
    end else if (code >= 8'h40 && code <= 8'hA0) begin
      g = gain_tbl(7'(code - 8'h40));
    end else begin
      g = '0;
    end
    return g;
  endfunction

  localparam logic [GainW-1:0] ResetGain = 16'd10363;

endpackage

`default_nettype wire

// ===== design/eight_channel_pcm_voice_mixer_unit.sv =====
// channel   dir  signals                      contents (lowest bit first)
// s_axis    in   tvalid tready tuser tdata    tuser: command; tdata: channel, address,
//                                             sample_value, length, rate_index,
//                                             volume_code, mix_in
// m_axis    out  tvalid tready tuser tdata    tuser: status; tdata: mix_out, active_mask
//
// non-tick commands go from accept through apply and finish to the result register
// tick visits 8 voices in issue, one voice per cycle, set by the one sample store read
// port and the shared multiplier, then drains the read and product stages and finishes
// reset clears voice state, gains to ResetGain; sample store is garbage until loaded
// a waiting result holds in the output register while the next item is accepted
`default_nettype none

module eight_channel_pcm_voice_mixer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // command
  // channel[3:0] address[15:4] sample_value[27:16] length[40:28]
  // rate_index[48:41] volume_code[56:49] mix_in[88:57] zero[95:89]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tuser,   // status
  output logic [39:0] m_axis_tdata    // mix_out[31:0] active_mask[39:32]
);
  import pcmmix_pkg::*;

  ctl_cmd_t         cmd;
  dp_sts_t          sts;
  logic [MixW-1:0]  mix_out;
  logic [MaskW-1:0] mask;

  pcmmix_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pcmmix_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .command_i      (s_axis_tuser),
    .channel_i      (s_axis_tdata[3:0]),
    .address_i      (s_axis_tdata[15:4]),
    .sample_value_i (s_axis_tdata[27:16]),
    .length_i       (s_axis_tdata[40:28]),
    .rate_index_i   (s_axis_tdata[48:41]),
    .volume_code_i  (s_axis_tdata[56:49]),
    .mix_in_i       (s_axis_tdata[88:57]),
    .mix_out_o      (mix_out),
    .status_o       (m_axis_tuser),
    .active_mask_o  (mask)
  );

  assign m_axis_tdata = {mask, mix_out};

endmodule

`default_nettype wire

// ===== design/pcmmix_ctrl.sv =====
`default_nettype none

module pcmmix_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [2:0]            in_cmd_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pcmmix_pkg::ctl_cmd_t  cmd_o,
  input  pcmmix_pkg::dp_sts_t   sts_i
);
  import pcmmix_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic [VoiceW-1:0] vcnt_q;
  logic              out_valid_q;
  logic              accept;
  logic              out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load_item = accept;
    cmd_o.apply     = (state_q == ST_APPLY);
    cmd_o.issue     = (state_q == ST_ISSUE);
    cmd_o.vidx      = vcnt_q;
    cmd_o.load_out  = (state_q == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            vcnt_q  <= '0;
            state_q <= (in_cmd_i == CMD_TICK) ? ST_ISSUE : ST_APPLY;
          end
        end
        ST_APPLY: begin
          state_q <= ST_FINISH;
        end
        ST_ISSUE: begin
          if (vcnt_q == VoiceW'(Voices - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            vcnt_q <= vcnt_q + VoiceW'(1);
          end
        end
        ST_DRAIN: begin
          if (!sts_i.busy) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_result_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside finish");

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_ISSUE) || (state_q == ST_APPLY))
    else $error("accepted item did not start work");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("waiting result dropped");
`endif

endmodule

`default_nettype wire

// ===== design/pcmmix_dp.sv =====
`default_nettype none

module pcmmix_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcmmix_pkg::ctl_cmd_t                cmd_i,
  output pcmmix_pkg::dp_sts_t                 sts_o,
  input  logic [pcmmix_pkg::CmdW-1:0]         command_i,
  input  logic [pcmmix_pkg::ChanW-1:0]        channel_i,
  input  logic [pcmmix_pkg::AddrW-1:0]        address_i,
  input  logic signed [pcmmix_pkg::SampleW-1:0] sample_value_i,
  input  logic [pcmmix_pkg::LengthW-1:0]      length_i,
  input  logic [pcmmix_pkg::RateW-1:0]        rate_index_i,
  input  logic [pcmmix_pkg::VolW-1:0]         volume_code_i,
  input  logic signed [pcmmix_pkg::MixW-1:0]  mix_in_i,
  output logic signed [pcmmix_pkg::MixW-1:0]  mix_out_o,
  output logic                                status_o,
  output logic [pcmmix_pkg::MaskW-1:0]        active_mask_o
);
  import pcmmix_pkg::*;

  // latched item
  logic [CmdW-1:0]    it_cmd_q;
  logic [ChanW-1:0]   it_ch_q;
  logic [AddrW-1:0]   it_addr_q;
  logic [SampleW-1:0] it_smp_q;
  logic [LengthW-1:0] it_len_q;
  logic [RateW-1:0]   it_rate_q;
  logic [VolW-1:0]    it_vol_q;

  // voice state
  logic [LenW-1:0]   len_q   [Voices];
  logic [PosW-1:0]   pos_q   [Voices];
  logic              fin_q   [Voices];
  logic [2:0]        rate_q  [Voices];
  logic [PhaseW-1:0] phase_q [Voices];
  logic [GainW-1:0]  gain_q  [Voices];

  logic [SampleW-1:0] mem [MemDepth];

  logic [SampleW-1:0]       rd_q;
  logic                     s1_act_q;
  logic [GainW-1:0]         s1_gain_q;
  logic signed [ProdW-1:0]  prod_q;
  logic                     s2_act_q;
  logic signed [MixW-1:0]   mix_q;

  logic signed [MixW-1:0]   out_mix_q;
  logic                     out_status_q;
  logic [MaskW-1:0]         out_mask_q;

  logic              ch_ok;
  logic [VoiceW-1:0] chv;
  logic              err;
  logic [LenW-1:0]   len_sat;
  logic [MemAW-1:0]  waddr;
  logic [MemAW-1:0]  raddr;
  logic              wen;
  logic [VoiceW-1:0] v;
  logic              v_act;
  logic [PhaseW-1:0] ph_sum;
  logic              step;
  logic [PhaseW-1:0] ph_next;
  logic [PosW:0]     pos_inc;
  logic              done;
  logic [MaskW-1:0]  mask;

  logic signed [ProdW-1:0]  biased;
  logic signed [ProdW-12:0] quot;
  logic signed [ProdW-10:0] x4;
  logic signed [LevelW-1:0] level;
  logic signed [MixW:0]     sum;
  logic signed [MixW-1:0]   sum_sat;

  assign ch_ok   = 32'(it_ch_q) < Voices;
  assign chv     = VoiceW'(it_ch_q);
  assign err     = (32'(it_cmd_q) <= 32'(CMD_RATE)) && !ch_ok;
  assign len_sat = (32'(it_len_q) > SamplesPerVoice) ? LenW'(SamplesPerVoice)
                                                     : LenW'(it_len_q);
  assign waddr   = {chv, PosW'(it_addr_q)};
  assign wen     = cmd_i.apply && ch_ok && (it_cmd_q == CMD_LOAD) &&
                   (32'(it_addr_q) < SamplesPerVoice);

  assign v       = cmd_i.vidx;
  assign v_act   = (len_q[v] != '0) && !fin_q[v];
  assign raddr   = {v, pos_q[v]};
  assign ph_sum  = phase_q[v] + PhaseW'(rate_of(rate_q[v]));
  assign step    = ph_sum >= PhaseW'(OutputRate);
  assign ph_next = step ? (ph_sum - PhaseW'(OutputRate)) : ph_sum;
  assign pos_inc = {1'b0, pos_q[v]} + (PosW+1)'(1);
  assign done    = 32'(pos_inc) >= 32'(len_q[v]);

  always_comb begin
    mask = '0;
    for (int i = 0; i < Voices; i++) begin
      if (i < MaskW) begin
        mask[i] = (len_q[i] != '0) && !fin_q[i];
      end
    end
  end

  // divide by 2048 toward zero, times 4, clamp to +-32767, add to mix, saturate
  always_comb begin
    biased = prod_q + (prod_q[ProdW-1] ? ProdW'(2047) : ProdW'(0));
    quot   = biased[ProdW-1:11];
    x4     = {quot, 2'b00};
    if (x4 > (ProdW-9)'(32767)) begin
      level = LevelW'(32767);
    end else if (x4 < -(ProdW-9)'(32767)) begin
      level = -LevelW'(32767);
    end else begin
      level = LevelW'(x4);
    end
    sum = (MixW+1)'(mix_q) + (MixW+1)'(level);
    if (sum > (MixW+1)'(33'sh0_7FFF_FFFF)) begin
      sum_sat = {1'b0, {(MixW-1){1'b1}}};
    end else if (sum < -(MixW+1)'(33'sh0_8000_0000)) begin
      sum_sat = {1'b1, {(MixW-1){1'b0}}};
    end else begin
      sum_sat = sum[MixW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= it_smp_q;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      it_cmd_q  <= command_i;
      it_ch_q   <= channel_i;
      it_addr_q <= address_i;
      it_smp_q  <= sample_value_i;
      it_len_q  <= length_i;
      it_rate_q <= rate_index_i;
      it_vol_q  <= volume_code_i;
      mix_q     <= (command_i == CMD_TICK) ? mix_in_i : '0;
    end else if (s2_act_q) begin
      mix_q <= sum_sat;
    end
    s1_gain_q <= gain_q[v];
    prod_q    <= $signed(rd_q) * $signed({1'b0, s1_gain_q});
    if (cmd_i.load_out) begin
      out_mix_q    <= mix_q;
      out_status_q <= err;
      out_mask_q   <= mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_act_q <= 1'b0;
      s2_act_q <= 1'b0;
      for (int i = 0; i < Voices; i++) begin
        len_q[i]   <= '0;
        pos_q[i]   <= '0;
        fin_q[i]   <= 1'b0;
        rate_q[i]  <= '0;
        phase_q[i] <= '0;
        gain_q[i]  <= ResetGain;
      end
    end else begin
      s1_act_q <= cmd_i.issue && v_act;
      s2_act_q <= s1_act_q;
      if (cmd_i.apply && ch_ok) begin
        case (it_cmd_q)
          CMD_PLAY: begin
            len_q[chv]   <= len_sat;
            pos_q[chv]   <= '0;
            fin_q[chv]   <= 1'b0;
            rate_q[chv]  <= rate_sel(it_rate_q);
            phase_q[chv] <= '0;
            gain_q[chv]  <= gain_of(it_vol_q);
          end
          CMD_STOP: begin
            len_q[chv]   <= '0;
            pos_q[chv]   <= '0;
            fin_q[chv]   <= 1'b0;
            phase_q[chv] <= '0;
          end
          CMD_VOLUME: gain_q[chv] <= gain_of(it_vol_q);
          CMD_RATE:   rate_q[chv] <= rate_sel(it_rate_q);
          default: ;
        endcase
      end
      if (cmd_i.issue && v_act) begin
        phase_q[v] <= ph_next;
        if (step) begin
          if (done) begin
            pos_q[v] <= '0;
            fin_q[v] <= 1'b1;
          end else begin
            pos_q[v] <= pos_inc[PosW-1:0];
          end
        end
      end
    end
  end

  assign sts_o.busy    = s1_act_q || s2_act_q;
  assign mix_out_o     = out_mix_q;
  assign status_o      = out_status_q;
  assign active_mask_o = out_mask_q;

`ifndef SYNTH
  a_stage_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_act_q |-> $past(s1_act_q))
    else $error("product stage without read stage");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |=> phase_q[$past(cmd_i.vidx)] < PhaseW'(OutputRate))
    else $error("phase out of range");

  a_drained_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(s1_act_q || s2_act_q))
    else $error("result taken before mix drained");
`endif

endmodule

`default_nettype wire
